// File: rtl/core/touch_sample_filter_pen_tracker_assert.svh
// ----------------------------------------------------------------------------
// Touch sample filter assertion macros
// Implication checks used by the touch sample filter RTL; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_FILTER_PEN_TRACKER_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_PEN_TRACKER_ASSERT_SVH
`ifndef SYNTH
`define TSF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tsf: same-cycle check failed");
`define TSF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tsf: next-cycle check failed");
`else
`define TSF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TSF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/tsf_pkg.sv
// ----------------------------------------------------------------------------
// Touch sample filter package
// Shared widths, codes, request types and arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int POS_W    = 16;
    localparam int GROUP_N  = 5;
    localparam int DROP_REQ = 1;
    localparam int DROP     = (2 * DROP_REQ >= GROUP_N) ? (GROUP_N - 1) / 2 : DROP_REQ;
    localparam int KEEP     = GROUP_N - 2 * DROP;
    localparam int SUM_W    = SAMPLE_W + $clog2(KEEP);
    localparam int SLOT_W   = $clog2(GROUP_N);
    localparam int GRP_W    = 2;

    // Exact division by KEEP: ceil(2^SH / KEEP) with SH = SUM_W + log2(KEEP).
    localparam int RECIP_SH = SUM_W + $clog2(KEEP);
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + KEEP - 1) / KEEP);

    localparam int GAIN_W   = 16;
    localparam int CAL_FRAC = 14;
    localparam int PROD_W   = GAIN_W + SAMPLE_W + 1;
    localparam int CAL_W    = 32;

    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(GROUP_N - 1);
    localparam logic [GRP_W-1:0]    GRP_X1    = 2'd0;
    localparam logic [GRP_W-1:0]    GRP_Y1    = 2'd1;
    localparam logic [GRP_W-1:0]    GRP_X2    = 2'd2;
    localparam logic [GRP_W-1:0]    GRP_Y2    = 2'd3;
    localparam logic [POS_W-1:0]    IDLE_POS  = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] LIMIT_RST = 12'd50;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef enum logic [1:0] {
        ACT_SCAN   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_ACK    = 2'd2
    } act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAW_MODE    = 3'd0,
        CFG_AGREE_LIMIT = 3'd1,
        CFG_X_GAIN      = 3'd2,
        CFG_X_OFFSET    = 3'd3,
        CFG_Y_GAIN      = 3'd4,
        CFG_Y_OFFSET    = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TOK_GROUP   = 2'd0,
        TOK_RELEASE = 2'd1,
        TOK_ACK     = 2'd2
    } tok_kind_t;

    typedef struct packed {
        logic    ins;
        logic    flush;
        sample_t din;
    } ins_req_t;

    function automatic sample_t abs_diff(input sample_t a, input sample_t b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [POS_W-1:0] calibrate(input logic signed [PROD_W-1:0] prod,
                                                   input logic signed [GAIN_W-1:0] off);
        logic [CAL_W-1:0] p;
        p = {{(CAL_W - PROD_W){prod[PROD_W-1]}}, prod}
          + {{(CAL_W - GAIN_W - CAL_FRAC){off[GAIN_W-1]}}, off, {CAL_FRAC{1'b0}}};
        if (p[CAL_W-1]) begin
            calibrate = '0;
        end else if (|p[CAL_W-2:CAL_FRAC+POS_W]) begin
            calibrate = IDLE_POS;
        end else begin
            calibrate = p[CAL_FRAC +: POS_W];
        end
    endfunction

endpackage

// File: rtl/core/tsf_cell.sv
// ----------------------------------------------------------------------------
// Touch sample filter sort cell
// One slot of the insertion sorter: keeps its value, or takes the new sample
// or the value of its left neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsf_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  tsf_pkg::ins_req_t req,
    input  logic              head,
    input  logic              left_gt,
    input  tsf_pkg::sample_t  left_val,
    input  logic              left_occ,
    output tsf_pkg::sample_t  val,
    output logic              occ,
    output logic              gt
);

    tsf_pkg::sample_t val_reg, val_next;
    logic             occ_reg, occ_next;

    assign gt  = !occ_reg || (req.din < val_reg);
    assign val = val_reg;
    assign occ = occ_reg;

    always_comb begin
        val_next = val_reg;
        occ_next = occ_reg;
        if (req.ins) begin
            if (req.flush) begin
                val_next = req.din;
                occ_next = head;
            end else if (gt) begin
                if (left_gt) begin
                    val_next = left_val;
                    occ_next = left_occ;
                end else begin
                    val_next = req.din;
                    occ_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

// File: rtl/core/tsf_sort_row.sv
// ----------------------------------------------------------------------------
// Touch sample filter sort row
// A row of sort cells holding one group in ascending order, with the sum of
// the kept middle entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "touch_sample_filter_pen_tracker_assert.svh"

module tsf_sort_row (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tsf_pkg::ins_req_t          req,
    output logic [tsf_pkg::SUM_W-1:0]  kept_sum
);

    tsf_pkg::sample_t val [tsf_pkg::GROUP_N];
    logic             occ [tsf_pkg::GROUP_N];
    logic             gt  [tsf_pkg::GROUP_N];

    for (genvar i = 0; i < tsf_pkg::GROUP_N; i++) begin : g_cell
        if (i == 0) begin : g_head
            tsf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .req      (req),
                .head     (1'b1),
                .left_gt  (1'b0),
                .left_val ('0),
                .left_occ (1'b0),
                .val      (val[i]),
                .occ      (occ[i]),
                .gt       (gt[i])
            );
        end else begin : g_body
            tsf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .req      (req),
                .head     (1'b0),
                .left_gt  (gt[i-1]),
                .left_val (val[i-1]),
                .left_occ (occ[i-1]),
                .val      (val[i]),
                .occ      (occ[i]),
                .gt       (gt[i])
            );
        end
    end

    always_comb begin
        kept_sum = '0;
        for (int i = tsf_pkg::DROP; i < tsf_pkg::GROUP_N - tsf_pkg::DROP; i++) begin
            kept_sum = kept_sum + tsf_pkg::SUM_W'(val[i]);
        end
    end

    for (genvar i = 1; i < tsf_pkg::GROUP_N; i++) begin : g_chk
        `TSF_ASSERT_IMP(a_sorted_prefix, aclk, aresetn, occ[i], occ[i-1] && (val[i-1] <= val[i]))
    end

endmodule

// File: rtl/core/touch_sample_filter_pen_tracker.sv
// ----------------------------------------------------------------------------
// Touch sample filter and pen tracker
// Trimmed-mean filtering of touch converter samples and pen press tracking.
//
// Requests arrive on the s_ stream: tuser holds the action (scan, sample or
// acknowledge), tdata the pen level and the converter sample. A pen-down scan
// starts a measurement of four groups of samples (X, Y, X, Y); each sample is
// inserted into a row of sort cells as it arrives. Results leave on the m_
// stream: release scans, acknowledges and the last sample of a measurement
// each give one result; other requests give none.
// One request is taken every cycle while s_tready is high. Between a request
// and its result lie register stages for the trimmed sum, the division by
// the kept count, agreement, the calibration multiply and the state update.
// When the receiver stalls, the stages fill up and s_tready falls only once
// no stage can move; empty stages keep taking requests meanwhile.
// Reset clears the press state, the position and the measurement in progress
// and loads the register defaults. Registers are written on the cfg_ channel,
// which is always ready; the user must write them only while no request is
// in flight, and the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "touch_sample_filter_pen_tracker_assert.svh"

module touch_sample_filter_pen_tracker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] pen_touching, [12:1] sample, [15:13] zero
    input  logic [tsf_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] action
    input  logic [tsf_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] pressed, [1] caught, [17:2] pos_x, [33:18] pos_y, [49:34] first_x,
    // [65:50] first_y, [66] reading_agreed, [71:67] zero
    output logic [tsf_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW = tsf_pkg::SAMPLE_W;
    localparam int PW = tsf_pkg::POS_W;

    logic                              raw_mode_reg;
    tsf_pkg::sample_t                  agree_limit_reg;
    logic signed [tsf_pkg::GAIN_W-1:0] x_gain_reg, x_offset_reg, y_gain_reg, y_offset_reg;

    logic                       acc;
    logic [1:0]                 act;
    logic                       pen;
    tsf_pkg::sample_t           smp;
    logic                       collecting_reg, collecting_next;
    logic [tsf_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [tsf_pkg::GRP_W-1:0]  grp_reg, grp_next;
    tsf_pkg::ins_req_t          ins_req;
    logic                       tok_vld;
    tsf_pkg::tok_kind_t         tok_kind;
    logic [tsf_pkg::SUM_W-1:0]  kept_sum;

    logic ld_a, ld_b, ld_c, ld_d, ld_e, ld_out;

    logic                       vld_a_reg;
    tsf_pkg::tok_kind_t         kind_a_reg;
    logic [tsf_pkg::GRP_W-1:0]  grp_a_reg;

    logic                       vld_b_reg;
    tsf_pkg::tok_kind_t         kind_b_reg;
    logic [tsf_pkg::GRP_W-1:0]  grp_b_reg;
    logic [tsf_pkg::SUM_W-1:0]  sum_b_reg;

    logic [tsf_pkg::SUM_W+tsf_pkg::RECIP_W-1:0] quot_prod;
    logic                       vld_c_reg;
    tsf_pkg::tok_kind_t         kind_c_reg;
    logic [tsf_pkg::GRP_W-1:0]  grp_c_reg;
    tsf_pkg::sample_t           mean_c_reg;

    tsf_pkg::sample_t           fx_reg, fy_reg, sx_reg;
    logic                       c_is_mid;
    logic                       agreed_c;
    logic [SW:0]                sum_x, sum_y;

    logic                       vld_d_reg;
    tsf_pkg::tok_kind_t         kind_d_reg;
    logic                       agreed_d_reg;
    tsf_pkg::sample_t           ax_d_reg, ay_d_reg;

    logic signed [tsf_pkg::PROD_W-1:0] px_next, py_next;
    logic                       vld_e_reg;
    tsf_pkg::tok_kind_t         kind_e_reg;
    logic                       agreed_e_reg;
    tsf_pkg::sample_t           ax_e_reg, ay_e_reg;
    logic signed [tsf_pkg::PROD_W-1:0] px_e_reg, py_e_reg;

    logic                       m_tvalid_reg;
    logic                       pressed_reg, pressed_next;
    logic                       caught_reg, caught_next;
    logic [PW-1:0]              cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [PW-1:0]              first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic                       agreed_reg, agreed_next;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_mode_reg    <= 1'b0;
            agree_limit_reg <= tsf_pkg::LIMIT_RST;
            x_gain_reg      <= '0;
            x_offset_reg    <= '0;
            y_gain_reg      <= '0;
            y_offset_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                tsf_pkg::CFG_RAW_MODE:    raw_mode_reg    <= cfg_data[0];
                tsf_pkg::CFG_AGREE_LIMIT: agree_limit_reg <= cfg_data[SW-1:0];
                tsf_pkg::CFG_X_GAIN:      x_gain_reg      <= cfg_data;
                tsf_pkg::CFG_X_OFFSET:    x_offset_reg    <= cfg_data;
                tsf_pkg::CFG_Y_GAIN:      y_gain_reg      <= cfg_data;
                tsf_pkg::CFG_Y_OFFSET:    y_offset_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage handshake, from the output back to the input.
    assign ld_out   = !m_tvalid_reg || m_tready;
    assign ld_e     = !vld_e_reg || ld_out;
    assign ld_d     = !vld_d_reg || ld_e;
    assign ld_c     = !vld_c_reg || ld_d;
    assign ld_b     = !vld_b_reg || ld_c;
    assign ld_a     = !vld_a_reg || ld_b;
    assign s_tready = ld_a;

    assign acc = s_tvalid && s_tready;
    assign act = s_tuser;
    assign pen = s_tdata[0];
    assign smp = s_tdata[SW:1];

    // Request decode and measurement sequencing.
    always_comb begin
        collecting_next = collecting_reg;
        slot_next       = slot_reg;
        grp_next        = grp_reg;
        ins_req.ins     = 1'b0;
        ins_req.flush   = (slot_reg == '0);
        ins_req.din     = smp;
        tok_vld         = 1'b0;
        tok_kind        = tsf_pkg::TOK_ACK;
        if (acc) begin
            case (act)
                tsf_pkg::ACT_SCAN: begin
                    slot_next       = '0;
                    grp_next        = tsf_pkg::GRP_X1;
                    collecting_next = pen;
                    if (!pen) begin
                        tok_vld  = 1'b1;
                        tok_kind = tsf_pkg::TOK_RELEASE;
                    end
                end
                tsf_pkg::ACT_ACK: begin
                    tok_vld  = 1'b1;
                    tok_kind = tsf_pkg::TOK_ACK;
                end
                tsf_pkg::ACT_SAMPLE: begin
                    if (collecting_reg) begin
                        ins_req.ins = 1'b1;
                        if (slot_reg == tsf_pkg::LAST_SLOT) begin
                            slot_next = '0;
                            tok_vld   = 1'b1;
                            tok_kind  = tsf_pkg::TOK_GROUP;
                            if (grp_reg == tsf_pkg::GRP_Y2) begin
                                collecting_next = 1'b0;
                                grp_next        = tsf_pkg::GRP_X1;
                            end else begin
                                grp_next = grp_reg + 1'b1;
                            end
                        end else begin
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    tsf_sort_row u_sort_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (ins_req),
        .kept_sum (kept_sum)
    );

    assign quot_prod = sum_b_reg * tsf_pkg::RECIP;

    assign c_is_mid = (kind_c_reg == tsf_pkg::TOK_GROUP) && (grp_c_reg != tsf_pkg::GRP_Y2);
    assign agreed_c = (tsf_pkg::abs_diff(fx_reg, sx_reg) < agree_limit_reg)
                   && (tsf_pkg::abs_diff(fy_reg, mean_c_reg) < agree_limit_reg);
    assign sum_x    = {1'b0, fx_reg} + {1'b0, sx_reg};
    assign sum_y    = {1'b0, fy_reg} + {1'b0, mean_c_reg};

    assign px_next  = x_gain_reg * $signed({1'b0, ax_d_reg});
    assign py_next  = y_gain_reg * $signed({1'b0, ay_d_reg});

    // Press tracking at the output stage.
    always_comb begin
        pressed_next = pressed_reg;
        caught_next  = caught_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        agreed_next  = agreed_reg;
        if (ld_out && vld_e_reg) begin
            agreed_next = 1'b0;
            case (kind_e_reg)
                tsf_pkg::TOK_RELEASE: begin
                    if (pressed_reg) begin
                        pressed_next = 1'b0;
                    end else begin
                        first_x_next = '0;
                        first_y_next = '0;
                        cur_x_next   = tsf_pkg::IDLE_POS;
                        cur_y_next   = tsf_pkg::IDLE_POS;
                    end
                end
                tsf_pkg::TOK_ACK: begin
                    caught_next = 1'b0;
                end
                tsf_pkg::TOK_GROUP: begin
                    agreed_next = agreed_e_reg;
                    if (agreed_e_reg) begin
                        if (raw_mode_reg) begin
                            cur_x_next = {{(PW - SW){1'b0}}, ax_e_reg};
                            cur_y_next = {{(PW - SW){1'b0}}, ay_e_reg};
                        end else begin
                            cur_x_next = tsf_pkg::calibrate(px_e_reg, x_offset_reg);
                            cur_y_next = tsf_pkg::calibrate(py_e_reg, y_offset_reg);
                        end
                    end
                    if (!pressed_reg) begin
                        pressed_next = 1'b1;
                        caught_next  = 1'b1;
                        first_x_next = cur_x_next;
                        first_y_next = cur_y_next;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            slot_reg       <= '0;
            grp_reg        <= tsf_pkg::GRP_X1;
            vld_a_reg      <= 1'b0;
            vld_b_reg      <= 1'b0;
            vld_c_reg      <= 1'b0;
            vld_d_reg      <= 1'b0;
            vld_e_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            pressed_reg    <= 1'b0;
            caught_reg     <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
        end else begin
            collecting_reg <= collecting_next;
            slot_reg       <= slot_next;
            grp_reg        <= grp_next;
            if (ld_a) begin
                vld_a_reg <= tok_vld;
            end
            if (ld_b) begin
                vld_b_reg <= vld_a_reg;
            end
            if (ld_c) begin
                vld_c_reg <= vld_b_reg;
            end
            if (ld_d) begin
                vld_d_reg <= vld_c_reg && !c_is_mid;
            end
            if (ld_e) begin
                vld_e_reg <= vld_d_reg;
            end
            if (ld_out) begin
                m_tvalid_reg <= vld_e_reg;
            end
            pressed_reg <= pressed_next;
            caught_reg  <= caught_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        agreed_reg <= agreed_next;
        if (ld_a) begin
            kind_a_reg <= tok_kind;
            grp_a_reg  <= grp_reg;
        end
        if (ld_b) begin
            kind_b_reg <= kind_a_reg;
            grp_b_reg  <= grp_a_reg;
            sum_b_reg  <= kept_sum;
        end
        if (ld_c) begin
            kind_c_reg <= kind_b_reg;
            grp_c_reg  <= grp_b_reg;
            mean_c_reg <= quot_prod[tsf_pkg::RECIP_SH +: SW];
        end
        if (ld_d) begin
            kind_d_reg   <= kind_c_reg;
            agreed_d_reg <= agreed_c;
            ax_d_reg     <= sum_x[SW:1];
            ay_d_reg     <= sum_y[SW:1];
            if (vld_c_reg && c_is_mid) begin
                case (grp_c_reg)
                    tsf_pkg::GRP_X1: fx_reg <= mean_c_reg;
                    tsf_pkg::GRP_Y1: fy_reg <= mean_c_reg;
                    tsf_pkg::GRP_X2: sx_reg <= mean_c_reg;
                    default: ;
                endcase
            end
        end
        if (ld_e) begin
            kind_e_reg   <= kind_d_reg;
            agreed_e_reg <= agreed_d_reg;
            ax_e_reg     <= ax_d_reg;
            ay_e_reg     <= ay_d_reg;
            px_e_reg     <= px_next;
            py_e_reg     <= py_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(tsf_pkg::M_TDATA_W - 4 * PW - 3){1'b0}}, agreed_reg,
                       first_y_reg, first_x_reg, cur_y_reg, cur_x_reg, caught_reg, pressed_reg};

    `TSF_ASSERT_IMP(a_slot_range, aclk, aresetn, 1'b1, slot_reg <= tsf_pkg::LAST_SLOT)
    `TSF_ASSERT_IMP(a_idle_counters, aclk, aresetn, !collecting_reg, (slot_reg == '0) && (grp_reg == tsf_pkg::GRP_X1))
    `TSF_ASSERT_NXT(a_group_token, aclk, aresetn, acc && (act == tsf_pkg::ACT_SAMPLE) && collecting_reg && (slot_reg == tsf_pkg::LAST_SLOT), vld_a_reg)
    `TSF_ASSERT_IMP(a_agreed_pressed, aclk, aresetn, m_tvalid_reg && agreed_reg, pressed_reg)

endmodule
